// ----- src/radix_digit_converter_top_assert.svh -----
// Assertion macros for the radix digit converter.
// Included by the top level; no other dependencies.
`ifndef RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/rdc_pkg.sv -----
// Shared types, constants and helper functions of the radix digit converter.
// No dependencies.
package rdc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BASE_W          = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;

    localparam logic [BASE_W-1:0] BASE_MIN  = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX  = 5'd16;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_F    = 7'd70;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture a new request
        logic div_step;  // one nibble of long division
        logic rd_en;     // read one stored digit
        logic out_load;  // latch the read digit into the output register
        logic idx_dec;   // advance to the next lower digit
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_nib;  // current step finishes one digit
        logic quo_zero;  // quotient of the current step is zero
        logic out_last;  // output register holds the final digit
    } t_sts;

    // Four restoring steps: divide {rem, nib} by base, rem < base.
    // Returns {quotient nibble, new remainder}.
    function automatic logic [2*DIGIT_W-1:0] rdc_div_nib(
        input logic [DIGIT_W-1:0] rem,
        input logic [DIGIT_W-1:0] nib,
        input logic [BASE_W-1:0]  base
    );
        logic [BASE_W-1:0]  p;
        logic [DIGIT_W-1:0] r;
        logic [DIGIT_W-1:0] q;
        r = rem;
        q = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            p = {r, nib[i]};
            if (p >= base) begin
                r    = DIGIT_W'(p - base);
                q[i] = 1'b1;
            end else begin
                r = p[DIGIT_W-1:0];
            end
        end
        return {q, r};
    endfunction

    function automatic logic [CHAR_W-1:0] rdc_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// ----- src/rdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rdc_ctrl.sv -----
// Sequencer of the radix digit converter: division phase, then digit emission.
// Depends on rdc_pkg.
module rdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  rdc_pkg::t_sts i_sts,
    output rdc_pkg::t_cmd o_cmd
);
    import rdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_WAIT,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.last_nib && i_sts.quo_zero) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.out_load = 1'b1;
                n_valid        = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_valid = 1'b0;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_dec = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;

endmodule

// ----- src/rdc_dp.sv -----
// Datapath: nibble-serial long division by the radix, digit store, output register.
// Depends on rdc_pkg and rdc_ram.
module rdc_dp #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdc_pkg::t_cmd               i_cmd,
    input  logic [VALUE_WIDTH-1:0]      i_value,
    input  logic [rdc_pkg::BASE_W-1:0]  i_base,
    output rdc_pkg::t_sts               o_sts,
    output logic [rdc_pkg::CHAR_W-1:0]  o_char,
    output logic                        o_last
);
    import rdc_pkg::*;

    localparam int NIB = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PW  = NIB * DIGIT_W;
    localparam int NW  = (NIB > 1) ? $clog2(NIB) : 1;
    localparam int AW  = $clog2(VALUE_WIDTH);
    localparam int CW  = $clog2(VALUE_WIDTH + 1);

    logic [PW-1:0]         r_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [BASE_W-1:0]     r_base;
    logic [NW-1:0]         r_nib;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;

    logic [2*DIGIT_W-1:0]  w_qr;
    logic [DIGIT_W-1:0]    n_rem;
    logic [PW+DIGIT_W-1:0] w_shift;
    logic [PW-1:0]         n_work;
    logic [BASE_W-1:0]     n_base;
    logic                  w_last_nib;
    logic [DIGIT_W-1:0]    w_rdata;

    // Top nibble of the running dividend against the radix
    assign w_qr    = rdc_div_nib(r_rem, r_work[PW-1 -: DIGIT_W], r_base);
    assign n_rem   = w_qr[DIGIT_W-1:0];
    assign w_shift = {r_work, w_qr[2*DIGIT_W-1:DIGIT_W]};
    assign n_work  = w_shift[PW-1:0];

    assign w_last_nib = (r_nib == NW'(NIB - 1));

    always_comb begin
        if (i_base < BASE_MIN) begin
            n_base = BASE_MIN;
        end else if (i_base > BASE_MAX) begin
            n_base = BASE_MAX;
        end else begin
            n_base = i_base;
        end
    end

    // Control: digit counter and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_nib   <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
            r_nib   <= '0;
        end else if (i_cmd.div_step) begin
            if (w_last_nib) begin
                r_count <= r_count + CW'(1);
                r_nib   <= '0;
            end else begin
                r_nib <= r_nib + NW'(1);
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= PW'(i_value);
            r_rem  <= '0;
            r_base <= n_base;
        end else if (i_cmd.div_step) begin
            r_work <= n_work;
            if (w_last_nib) begin
                r_rem <= '0;
                r_idx <= r_count[AW-1:0];
            end else begin
                r_rem <= n_rem;
            end
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.out_load) begin
            r_char <= rdc_to_ascii(w_rdata);
            r_last <= (r_idx == '0);
        end
    end

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.div_step && w_last_nib),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (n_rem),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign o_sts.last_nib = w_last_nib;
    assign o_sts.quo_zero = (n_work == '0);
    assign o_sts.out_last = r_last;
    assign o_char         = r_char;
    assign o_last         = r_last;

endmodule

// ----- src/radix_digit_converter_top.sv -----
// Radix digit converter: integer to base-2..16 ASCII digit stream, MSD first.
// Depends on rdc_pkg, rdc_ctrl, rdc_dp (with rdc_ram) and the assertion header.
//
//   channel   dir  data (low bit up)                            last
//   s (req)   in   value[VALUE_WIDTH], base[5], zero pad        -
//   m (digit) out  digit_char[7], zero pad                      last_digit
//
// A request is taken only while the block is idle. Each digit costs one pass
// of the nibble-serial divider over the whole value, which retires four
// quotient bits a cycle; it is then read back from the digit RAM through the
// read, wait and output states and presented, most significant digit first.
// Reset is synchronous, active low, and clears the sequencer and digit count.
// A stall on the digit side holds the current digit in the output register.
`include "radix_digit_converter_top_assert.svh"

module radix_digit_converter_top #(
    parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // value [VALUE_WIDTH-1:0], base [VALUE_WIDTH+4:VALUE_WIDTH], zero pad
    input  logic [((VALUE_WIDTH + rdc_pkg::BASE_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // digit_char [6:0], zero pad [7]
    output logic [7:0]                                    o_m_tdata,
    output logic                                          o_m_tlast
);
    import rdc_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [CHAR_W-1:0] w_char;
    logic              w_last;

    // Handshake summaries for the checks below
    logic              w_req_acc;
    logic              w_dig_end;
    logic              w_dig_mid;
    logic              w_char_ok;
    logic              w_idle;
    logic              w_fetch;

    // Sequencer: accept a request, run the divider until the quotient is zero,
    // then walk the stored digits from the most significant down.
    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Divider, digit RAM and output register
    rdc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_value (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_base  (i_s_tdata[VALUE_WIDTH +: BASE_W]),
        .o_sts   (w_sts),
        .o_char  (w_char),
        .o_last  (w_last)
    );

    assign o_m_tdata = {1'b0, w_char};
    assign o_m_tlast = w_last;

    assign w_req_acc = i_s_tvalid && o_s_tready;
    assign w_dig_end = o_m_tvalid && i_m_tready && o_m_tlast;
    assign w_dig_mid = o_m_tvalid && i_m_tready && !o_m_tlast;
    assign w_char_ok = (w_char >= CHAR_ZERO && w_char <= CHAR_NINE) ||
                       (w_char >= CHAR_A && w_char <= CHAR_F);
    assign w_idle    = o_s_tready && !o_m_tvalid;
    assign w_fetch   = !o_s_tready && !o_m_tvalid;

    // No new request while a digit is still on offer
    `RDC_ASSERT_NOW(a_req_idle, i_clk, i_rst_n, w_req_acc, !o_m_tvalid, "request during output")

    // Every digit presented is a legal ASCII digit
    `RDC_ASSERT_NOW(a_char_range, i_clk, i_rst_n, o_m_tvalid, w_char_ok, "digit out of range")

    // After the final digit the block is idle again
    `RDC_ASSERT_NEXT(a_idle_after_end, i_clk, i_rst_n, w_dig_end, w_idle, "not idle at end")

    // After an inner digit the block fetches the next one and stays busy
    `RDC_ASSERT_NEXT(a_busy_after_mid, i_clk, i_rst_n, w_dig_mid, w_fetch, "run ended early")

endmodule
